[hdl/swht_pkg.sv]
// shared constants and index helpers for the sequency walsh-hadamard transform
package swht_pkg;

	localparam int MAX_LOG2 = 6;
	localparam int SAMPLE_W = 16;
	localparam int DEPTH    = 1 << MAX_LOG2;
	localparam int ADDR_W   = MAX_LOG2;
	localparam int BUF_W    = SAMPLE_W + MAX_LOG2 + 1;
	localparam int COEF_W   = 19;
	localparam int LOG2_W   = 3;
	localparam int IDX_W    = 1;
	localparam int CFG_W    = 3;
	localparam int FRAC_W   = 16;
	localparam int FACT_W   = FRAC_W + 2;
	localparam int PROD_W   = BUF_W + FACT_W;

	localparam logic [IDX_W-1:0] REG_LOG2_SIZE = 1'b0;
	localparam logic [IDX_W-1:0] REG_DIRECTION = 1'b1;

	localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;

	// 1/sqrt(2) and 1.0 in q16
	localparam logic signed [FACT_W-1:0] INV_SQRT2_Q16 = 18'sd46341;
	localparam logic signed [FACT_W-1:0] ONE_Q16       = 18'sd65536;

	// clamp the size register to the supported range
	function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] l);
		logic [LOG2_W-1:0] r;
		r = l;
		if (l == '0)
			r = LOG2_W'(1);
		else if (l > LOG2_W'(MAX_LOG2))
			r = LOG2_W'(MAX_LOG2);
		return r;
	endfunction

	// natural hadamard row of sequency index k: bit reverse of gray code over l bits
	function automatic logic [ADDR_W-1:0] seq_row(input logic [ADDR_W-1:0] k,
		input logic [LOG2_W-1:0] l);
		logic [ADDR_W-1:0] g;
		logic [ADDR_W-1:0] r;
		g = k ^ (k >> 1);
		for (int b = 0; b < ADDR_W; b++)
			r[b] = g[ADDR_W-1-b];
		return r >> (LOG2_W'(MAX_LOG2) - l);
	endfunction

endpackage

[hdl/sequency_walsh_hadamard_transform.sv]
// sequency-ordered orthonormal walsh-hadamard transform, one shared butterfly unit
//
// s_* channel takes N = 2^l samples, l being log2_size clamped to 1..6 (natural
// order forward, sequency order inverse). After the N-th item the block stops taking
// input, runs log2(N) stages of N/2 butterflies through one add/subtract unit on a
// 64-entry work memory, then emits N coefficients on m_*, scaled by 1/sqrt(N), rounded
// and saturated; m_tlast marks the N-th one.
// Steps: a butterfly reads both entries, writes the sum, then writes the difference;
// the memory write port sets the butterfly rate. Each coefficient passes through a
// memory read, a scale multiply, and round and saturate before the next is read.
// Reset clears the sequencer and the load count, sets log2_size to 6 and direction
// to forward; memory contents need no reset since every block writes all N entries.
// A stalled receiver holds the current result in the output register and pauses
// emission; input is taken again once the last result sits in the output register.
// A configuration write restarts loading and drops a partly loaded block.
module sequency_walsh_hadamard_transform (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [swht_pkg::IDX_W-1:0]         cfg_index,
	input  logic [swht_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [swht_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // [18:0] coefficient, rest zero
	output logic                               m_tlast
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BF_RD,
		ST_BF_WA,
		ST_BF_WB,
		ST_EM_RD,
		ST_EM_MUL,
		ST_EM_OUT
	} state_t;

	localparam logic signed [swht_pkg::PROD_W:0] COEF_MAX =
		(swht_pkg::PROD_W+1)'(262143);
	localparam logic signed [swht_pkg::PROD_W:0] COEF_MIN =
		-(swht_pkg::PROD_W+1)'(262144);

	state_t                               state_q;
	logic [swht_pkg::LOG2_W-1:0]          log2_q;
	logic                                 dir_q;
	logic [swht_pkg::ADDR_W-1:0]          cnt_q;      // load count and output index
	logic [swht_pkg::ADDR_W-2:0]          bf_q;       // butterfly within stage
	logic [swht_pkg::LOG2_W-1:0]          stage_q;
	logic signed [swht_pkg::BUF_W-1:0]    diff_q;
	logic signed [swht_pkg::PROD_W-1:0]   prod_q;
	logic                                 out_valid_q;
	logic signed [swht_pkg::COEF_W-1:0]   coef_q;
	logic                                 last_q;

	logic [swht_pkg::BUF_W-1:0]           mem [swht_pkg::DEPTH];
	logic signed [swht_pkg::BUF_W-1:0]    rdata0_q;
	logic signed [swht_pkg::BUF_W-1:0]    rdata1_q;

	logic [swht_pkg::LOG2_W-1:0]          eff_l;
	logic [swht_pkg::ADDR_W-1:0]          n_m1;
	logic [swht_pkg::ADDR_W-2:0]          half_m1;
	logic [swht_pkg::ADDR_W-1:0]          bf_ext;
	logic [swht_pkg::ADDR_W-1:0]          span;
	logic [swht_pkg::ADDR_W-1:0]          addr_a;
	logic [swht_pkg::ADDR_W-1:0]          addr_b;
	logic [swht_pkg::ADDR_W-1:0]          load_addr;
	logic [swht_pkg::ADDR_W-1:0]          emit_addr;
	logic [swht_pkg::ADDR_W-1:0]          raddr0;
	logic                                 we;
	logic [swht_pkg::ADDR_W-1:0]          waddr;
	logic [swht_pkg::BUF_W-1:0]           wdata;
	logic signed [swht_pkg::FACT_W-1:0]   factor;
	logic [4:0]                           shamt;
	logic signed [swht_pkg::PROD_W:0]     rounded;
	logic signed [swht_pkg::PROD_W:0]     shifted;
	logic signed [swht_pkg::COEF_W-1:0]   coef_sat;
	logic                                 out_free;
	logic                                 emit;
	logic                                 in_acc;

	always_comb begin
		eff_l     = swht_pkg::eff_log2(log2_q);
		n_m1      = swht_pkg::ADDR_W'((7'd1 << eff_l) - 7'd1);
		half_m1   = n_m1[swht_pkg::ADDR_W-1:1];
		// insert a zero at bit stage_q of the butterfly count to get the lower address
		bf_ext    = {1'b0, bf_q};
		span      = swht_pkg::ADDR_W'(1) << stage_q;
		addr_a    = ((bf_ext >> stage_q) << (stage_q + swht_pkg::LOG2_W'(1)))
			| (bf_ext & (span - swht_pkg::ADDR_W'(1)));
		addr_b    = addr_a | span;
		load_addr = dir_q ? swht_pkg::seq_row(cnt_q, eff_l) : cnt_q;
		emit_addr = dir_q ? cnt_q : swht_pkg::seq_row(cnt_q, eff_l);
		raddr0    = (state_q == ST_EM_RD) ? emit_addr : addr_a;
		in_acc    = s_tvalid && s_tready;
	end

	always_comb begin
		we    = 1'b0;
		waddr = load_addr;
		wdata = {{(swht_pkg::BUF_W-swht_pkg::SAMPLE_W){s_tdata[swht_pkg::SAMPLE_W-1]}},
			s_tdata};
		case (state_q)
			ST_LOAD: begin
				we = in_acc;
			end
			ST_BF_WA: begin
				we    = 1'b1;
				waddr = addr_a;
				wdata = rdata0_q + rdata1_q;
			end
			ST_BF_WB: begin
				we    = 1'b1;
				waddr = addr_b;
				wdata = diff_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[addr_b];
	end

	// scale: even sizes use 1.0 so both cases shift by 16 + floor(l/2)
	always_comb begin
		factor   = eff_l[0] ? swht_pkg::INV_SQRT2_Q16 : swht_pkg::ONE_Q16;
		shamt    = 5'(swht_pkg::FRAC_W) + 5'(eff_l >> 1);
		rounded  = {prod_q[swht_pkg::PROD_W-1], prod_q}
			+ ((swht_pkg::PROD_W+1)'(1) <<< (shamt - 5'd1));
		shifted  = rounded >>> shamt;
		if (shifted > COEF_MAX)
			coef_sat = swht_pkg::COEF_W'(COEF_MAX);
		else if (shifted < COEF_MIN)
			coef_sat = swht_pkg::COEF_W'(COEF_MIN);
		else
			coef_sat = swht_pkg::COEF_W'(shifted);
		out_free = !out_valid_q || m_tready;
		emit     = !cfg_we && (state_q == ST_EM_OUT) && out_free;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BF_WA)
			diff_q <= rdata0_q - rdata1_q;
		if (state_q == ST_EM_MUL)
			prod_q <= rdata0_q * factor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			log2_q      <= swht_pkg::LOG2_RESET;
			dir_q       <= 1'b0;
			cnt_q       <= '0;
			bf_q        <= '0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
			coef_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == swht_pkg::REG_LOG2_SIZE)
					log2_q <= cfg_data;
				else
					dir_q <= cfg_data[0];
				state_q <= ST_LOAD;
				cnt_q   <= '0;
			end else begin
				case (state_q)
					ST_LOAD: begin
						if (in_acc) begin
							if (cnt_q == n_m1) begin
								cnt_q   <= '0;
								bf_q    <= '0;
								stage_q <= '0;
								state_q <= ST_BF_RD;
							end else begin
								cnt_q <= cnt_q + swht_pkg::ADDR_W'(1);
							end
						end
					end
					ST_BF_RD: begin
						state_q <= ST_BF_WA;
					end
					ST_BF_WA: begin
						state_q <= ST_BF_WB;
					end
					ST_BF_WB: begin
						if (bf_q == half_m1) begin
							bf_q <= '0;
							if (stage_q == eff_l - swht_pkg::LOG2_W'(1)) begin
								cnt_q   <= '0;
								state_q <= ST_EM_RD;
							end else begin
								stage_q <= stage_q + swht_pkg::LOG2_W'(1);
								state_q <= ST_BF_RD;
							end
						end else begin
							bf_q    <= bf_q + (swht_pkg::ADDR_W-1)'(1);
							state_q <= ST_BF_RD;
						end
					end
					ST_EM_RD: begin
						state_q <= ST_EM_MUL;
					end
					ST_EM_MUL: begin
						state_q <= ST_EM_OUT;
					end
					ST_EM_OUT: begin
						if (out_free) begin
							coef_q      <= coef_sat;
							last_q      <= (cnt_q == n_m1);
							if (cnt_q == n_m1) begin
								cnt_q   <= '0;
								state_q <= ST_LOAD;
							end else begin
								cnt_q   <= cnt_q + swht_pkg::ADDR_W'(1);
								state_q <= ST_EM_RD;
							end
						end
					end
					default: begin
						state_q <= ST_LOAD;
					end
				endcase
			end
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24-swht_pkg::COEF_W){1'b0}}, coef_q};
	assign m_tlast  = last_q;

endmodule

[sim/sequency_coefficient_checker.sv]
`timescale 1ns / 1ps
// watches the sample and coefficient channels, predicts each coefficient and compares it
module sequency_coefficient_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swht_pkg::IDX_W-1:0]    cfg_index,
	input  logic [swht_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [swht_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [23:0]                   m_tdata,   // [18:0] coefficient, rest zero
	input  logic                          m_tlast,
	output int                            mismatches,
	output int                            results_owed
);

	localparam longint RECIP_SQRT2_Q16 = 46341;
	localparam longint COEF_HI = 262143;
	localparam longint COEF_LO = -262144;

	typedef struct packed {
		logic [18:0] coefficient;
		logic        last;
	} coef_item_t;

	logic [2:0] size_reg;
	logic       inverse;
	longint     work [64];
	int         fill;
	coef_item_t pending_coefs[$];

	function automatic int effective_log2(input logic [2:0] v);
		int l;
		l = v;
		if (l < 1)
			l = 1;
		if (l > swht_pkg::MAX_LOG2)
			l = swht_pkg::MAX_LOG2;
		return l;
	endfunction

	// natural hadamard row for sequency index k: gray code, then bit reversal over l bits
	function automatic int sequency_row(input int k, input int l);
		int g;
		int r;
		g = k ^ (k >> 1);
		r = 0;
		for (int b = 0; b < l; b++) begin
			r = (r << 1) | (g & 1);
			g = g >> 1;
		end
		return r;
	endfunction

	// divide by sqrt(n), halves go toward +inf, then clamp to 19 bits
	function automatic logic [18:0] scale_to_coef(input longint x, input int l);
		longint y;
		int s;
		if (l % 2 == 0) begin
			s = l / 2;
			y = (x + (longint'(1) <<< (s - 1))) >>> s;
		end else begin
			s = 16 + (l - 1) / 2;
			y = (x * RECIP_SQRT2_Q16 + (longint'(1) <<< (s - 1))) >>> s;
		end
		if (y > COEF_HI)
			y = COEF_HI;
		if (y < COEF_LO)
			y = COEF_LO;
		return y[18:0];
	endfunction

	task automatic transform_block(input int l);
		int n;
		int half;
		int src;
		longint a;
		longint b;
		coef_item_t item;
		n = 1 << l;
		for (int span = 2; span <= n; span = span * 2) begin
			half = span / 2;
			for (int i = 0; i < n; i += span) begin
				for (int j = 0; j < half; j++) begin
					a = work[i + j];
					b = work[i + j + half];
					work[i + j] = a + b;
					work[i + j + half] = a - b;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			src = inverse ? k : sequency_row(k, l);
			item.coefficient = scale_to_coef(work[src], l);
			item.last = (k == n - 1);
			pending_coefs.push_back(item);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		coef_item_t want;
		int l;
		int pos;
		if (!arst_n) begin
			size_reg = swht_pkg::LOG2_RESET;
			inverse = 1'b0;
			fill = 0;
			pending_coefs.delete();
			results_owed <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_coefs.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected coefficient, expected none got %0d last %0b",
						$time, $signed(m_tdata[18:0]), m_tlast);
				end else begin
					want = pending_coefs.pop_front();
					if (m_tdata[18:0] !== want.coefficient) begin
						mismatches++;
						$display("%0t: coefficient expected %0d got %0d", $time,
							$signed(want.coefficient), $signed(m_tdata[18:0]));
					end
					if (m_tlast !== want.last) begin
						mismatches++;
						$display("%0t: last expected %0b got %0b", $time, want.last, m_tlast);
					end
					if (m_tdata[23:19] !== 5'd0) begin
						mismatches++;
						$display("%0t: tdata padding expected 0 got %h", $time, m_tdata[23:19]);
					end
				end
			end

			// any register write restarts loading
			if (cfg_we) begin
				if (cfg_index == swht_pkg::REG_LOG2_SIZE)
					size_reg = cfg_data;
				else if (cfg_index == swht_pkg::REG_DIRECTION)
					inverse = cfg_data[0];
				fill = 0;
			end

			if (s_tvalid && s_tready) begin
				l = effective_log2(size_reg);
				if (fill >= (1 << l))
					fill = 0;
				pos = inverse ? sequency_row(fill, l) : fill;
				work[pos] = longint'($signed(s_tdata));
				fill++;
				if (fill == (1 << l)) begin
					transform_block(l);
					fill = 0;
				end
			end

			results_owed <= pending_coefs.size();
		end
	end

endmodule

[sim/sequency_walsh_hadamard_transform_test.sv]
`timescale 1ns / 1ps
// top of the testbench: clock, reset, sample and coefficient stimulus, and the verdict
module sequency_walsh_hadamard_transform_test;

	localparam int RANDOM_ITEMS = 180;
	localparam int CYCLE_LIMIT  = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [swht_pkg::IDX_W-1:0]    cfg_index = '0;
	logic [swht_pkg::CFG_W-1:0]    cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [swht_pkg::SAMPLE_W-1:0] s_tdata = '0;   // [15:0] sample
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;        // [18:0] coefficient, rest zero
	logic                          m_tlast;

	int mismatches;
	int results_owed;
	int cycles = 0;
	int blk_len = 64;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sequency_walsh_hadamard_transform uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sequency_coefficient_checker coef_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.results_owed(results_owed)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls per item, with calm stretches
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic program_mode(input bit wr_size, input logic [2:0] size_val,
		input bit wr_dir, input logic [2:0] dir_val);
		int l;
		if (wr_size) begin
			cfg_we <= 1'b1;
			cfg_index <= swht_pkg::REG_LOG2_SIZE;
			cfg_data <= size_val;
			@(posedge clk);
			l = size_val;
			if (l < 1)
				l = 1;
			if (l > swht_pkg::MAX_LOG2)
				l = swht_pkg::MAX_LOG2;
			blk_len = 1 << l;
		end
		if (wr_dir) begin
			cfg_we <= 1'b1;
			cfg_index <= swht_pkg::REG_DIRECTION;
			cfg_data <= dir_val;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input logic [swht_pkg::SAMPLE_W-1:0] value);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	// drain every owed coefficient, then let the block sit idle
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] draw_sample(input int fill_mode);
		int v;
		case (fill_mode)
			1: v = 32767;
			2: v = -32768;
			3: v = int'($urandom_range(0, 8)) - 4;
			4: v = $urandom_range(0, 1) ? 32767 : -32768;
			default: v = $urandom_range(0, 65535);
		endcase
		return v[15:0];
	endfunction

	initial begin
		int n_blk;
		int fill_mode;
		int extra;
		int random_sent;
		int r;
		logic [2:0] size_val;
		bit wr_size;
		bit wr_dir;
		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size 0 behaves as size 1
		program_mode(1'b1, 3'd0, 1'b1, 3'd0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		settle();
		// only bit 0 of the direction write counts
		program_mode(1'b1, 3'd1, 1'b1, 3'b111);
		send_sample(16'h8000);
		send_sample(16'h8000);
		settle();
		program_mode(1'b1, 3'd2, 1'b0, 3'd0);
		send_sample(16'h0001);
		send_sample(16'h0002);
		send_sample(16'hFFFD);
		send_sample(16'h7FFF);
		settle();
		program_mode(1'b1, 3'd3, 1'b1, 3'b110);
		repeat (8) send_sample(16'h8000);
		settle();
		// partly loaded block, dropped by the next write
		repeat (3) send_sample(16'($urandom));
		settle();
		program_mode(1'b1, 3'd2, 1'b0, 3'd0);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'h7FFF);
		send_sample(16'h8001);
		settle();

		while (random_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			case (r)
				0: size_val = 3'd7;
				1: size_val = 3'd6;
				2: size_val = 3'd0;
				3: size_val = 3'd5;
				default: size_val = 3'($urandom_range(1, 4));
			endcase
			wr_size = ($urandom_range(0, 3) != 0);
			wr_dir = $urandom_range(0, 1);
			if (!wr_size && !wr_dir)
				wr_dir = 1'b1;
			program_mode(wr_size, size_val, wr_dir, 3'($urandom_range(0, 7)));

			n_blk = (blk_len >= 32) ? 1 : $urandom_range(1, 3);
			repeat (n_blk) begin
				fill_mode = $urandom_range(0, 5);
				repeat (blk_len) begin
					send_sample(draw_sample(fill_mode));
					random_sent++;
				end
			end
			// trailing partial block that the next write throws away
			if ($urandom_range(0, 4) == 0) begin
				extra = $urandom_range(1, blk_len - 1);
				repeat (extra) send_sample(draw_sample(0));
			end
			settle();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
hdl/swht_pkg.sv
hdl/sequency_walsh_hadamard_transform.sv
sim/sequency_coefficient_checker.sv
sim/sequency_walsh_hadamard_transform_test.sv
